/* hdl/assert_macros.svh */
// Assertion macros shared by the nearest peer block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication check, disabled while in reset
`define NPRB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never hold, disabled while in reset
`define NPRB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

/* hdl/nprb_pkg.sv */
// Types and constants for the nearest peer range and bearing block.
// No dependencies.
package nprb_pkg;
  localparam int unsigned TabLen = 24;
  localparam int unsigned CoordWidth = 16;
  localparam logic [15:0] NoRange = 16'hFFFF;
  localparam logic [15:0] HalfTurn = 16'h8000;

  typedef enum logic [2:0] {
    ST_SCAN, ST_ANGLE_INIT, ST_ITER, ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] own_x;
    logic signed [CoordWidth-1:0] own_y;
    logic signed [15:0]           own_heading;
    logic signed [CoordWidth-1:0] peer_x;
    logic signed [CoordWidth-1:0] peer_y;
    logic signed [31:0]           peer_word;
    logic                         peer_is_self;
    logic                         last_peer;
  } peer_item_t;

  typedef struct packed {
    logic               found;
    logic        [15:0] range;
    logic signed [15:0] bearing;
    logic signed [31:0] nearest_word;
  } peer_fix_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic start;
    logic step;
  } ctrl_t;

  typedef struct packed {
    logic done;
  } stat_t;

  function automatic logic [15:0] atan_lut(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0: v = 16'd8192;  5'd1: v = 16'd4836; 5'd2: v = 16'd2555;
      5'd3: v = 16'd1297;  5'd4: v = 16'd651;  5'd5: v = 16'd326;
      5'd6: v = 16'd163;   5'd7: v = 16'd81;   5'd8: v = 16'd41;
      5'd9: v = 16'd20;    5'd10: v = 16'd10;  5'd11: v = 16'd5;
      5'd12: v = 16'd3;    5'd13: v = 16'd1;   5'd14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction
endpackage

/* hdl/nprb_if.sv */
// Valid/ready channel carrying a payload of type T.
// Depends on nothing.
interface nprb_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/nprb_ctrl.sv */
// Sequencer of the nearest peer block: scan, angle and root iterations, result.
// Depends on nprb_pkg and assert_macros.svh.
module nprb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output nprb_pkg::ctrl_t ctrl_o,
  input  nprb_pkg::stat_t stat_i
);
  import nprb_pkg::*;
  `include "assert_macros.svh"

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SCAN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SCAN: if (in_valid_i && in_last_i) state_d = ST_ANGLE_INIT;
      ST_ANGLE_INIT: state_d = ST_ITER;
      ST_ITER: if (stat_i.done) state_d = ST_OUT;
      ST_OUT: if (out_ready_i) state_d = ST_SCAN;
      default: state_d = ST_SCAN;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_SCAN);
    out_valid_o = (state_q == ST_OUT);
    ctrl_o.accept = (state_q == ST_SCAN) && in_valid_i;
    ctrl_o.start  = (state_q == ST_ANGLE_INIT);
    ctrl_o.step   = (state_q == ST_ITER);
    ctrl_o.clear  = (state_q == ST_OUT) && out_ready_i;
  end

  `NPRB_ASSERT_NEVER(a_no_in_while_busy, clk_i, rst_ni, out_valid_o && in_ready_o, "ready during output")
  `NPRB_ASSERT(a_last_starts, clk_i, rst_ni, (ctrl_o.accept && in_last_i |=> ctrl_o.start), "scan end lost")
  `NPRB_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i |=> out_valid_o), "result dropped")
endmodule

/* hdl/nprb_dp.sv */
// Datapath: per-peer distance compare, then CORDIC angle and bitwise root.
// Depends on nprb_pkg.
module nprb_dp #(
  parameter int unsigned CoordWidth = 16,
  parameter int unsigned AngleSteps = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [15:0]                  max_range_i,
  input  logic signed [CoordWidth-1:0] own_x_i,
  input  logic signed [CoordWidth-1:0] own_y_i,
  input  logic signed [15:0]           own_heading_i,
  input  logic signed [CoordWidth-1:0] peer_x_i,
  input  logic signed [CoordWidth-1:0] peer_y_i,
  input  logic signed [31:0]           peer_word_i,
  input  logic                         peer_is_self_i,
  input  nprb_pkg::ctrl_t              ctrl_i,
  output nprb_pkg::stat_t              stat_o,
  output logic                         found_o,
  output logic [15:0]                  range_o,
  output logic signed [15:0]           bearing_o,
  output logic signed [31:0]           nearest_word_o
);
  import nprb_pkg::*;

  localparam int unsigned DW = CoordWidth + 1;
  localparam int unsigned CW = 17 + 14 + 3;
  localparam int unsigned NIter = (AngleSteps < TabLen) ? AngleSteps : TabLen;
  localparam int unsigned RootSteps = 18;
  localparam int unsigned Iters = (NIter > RootSteps) ? NIter : RootSteps;

  logic signed [DW-1:0] dx, dy;
  logic dx_ok, dy_ok, in_rng;
  logic [32:0] dsq, lim;
  logic [32:0] best_q;
  logic signed [16:0] bdx_q, bdy_q;
  logic [31:0] bword_q;
  logic have_q;
  logic [15:0] head_q;

  assign dx = DW'(peer_x_i) - DW'(own_x_i);
  assign dy = DW'(peer_y_i) - DW'(own_y_i);
  always_comb begin
    dx_ok = (dx >= -DW'(65535)) && (dx <= DW'(65535));
    dy_ok = (dy >= -DW'(65535)) && (dy <= DW'(65535));
    if (DW <= 17) begin
      dx_ok = 1'b1;
      dy_ok = 1'b1;
    end
  end
  logic signed [16:0] dx17, dy17;
  assign dx17 = dx[16:0];
  assign dy17 = dy[16:0];
  logic signed [33:0] sxx, syy;
  assign sxx = 34'(dx17) * 34'(dx17);
  assign syy = 34'(dy17) * 34'(dy17);
  assign dsq = 33'(sxx + syy);
  assign lim = 33'(max_range_i) * 33'(max_range_i);
  assign in_rng = dx_ok && dy_ok && (dsq < lim) && (dsq < best_q);

  // CORDIC and root registers
  logic signed [CW-1:0] cx_q, cy_q;
  logic [15:0] z_q;
  logic [4:0] it_q;
  logic [33:0] rn_q, rr_q;
  logic [35:0] rb_q;
  logic zero_vec;
  assign zero_vec = (bdx_q == '0) && (bdy_q == '0);

  logic signed [CW-1:0] xs, ys;
  logic [35:0] trial;
  assign xs = cx_q >>> it_q;
  assign ys = cy_q >>> it_q;
  assign trial = 36'(rr_q) + rb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= '1;
      bdx_q   <= '0;
      bdy_q   <= '0;
      bword_q <= '0;
      have_q  <= 1'b0;
      it_q    <= '0;
      head_q  <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      z_q     <= '0;
      rn_q    <= '0;
      rr_q    <= '0;
      rb_q    <= '0;
    end else if (ctrl_i.clear) begin
      best_q  <= '1;
      bdx_q   <= '0;
      bdy_q   <= '0;
      bword_q <= '0;
      have_q  <= 1'b0;
    end else if (ctrl_i.accept) begin
      head_q <= own_heading_i;
      if (!peer_is_self_i && in_rng) begin
        best_q  <= dsq;
        bdx_q   <= dx17;
        bdy_q   <= dy17;
        bword_q <= peer_word_i;
        have_q  <= 1'b1;
      end
    end else if (ctrl_i.start) begin
      it_q <= '0;
      if (bdx_q < 0) begin
        cx_q <= -(CW'(bdx_q) <<< 14);
        cy_q <= -(CW'(bdy_q) <<< 14);
        z_q  <= HalfTurn;
      end else begin
        cx_q <= CW'(bdx_q) <<< 14;
        cy_q <= CW'(bdy_q) <<< 14;
        z_q  <= '0;
      end
      rn_q <= 34'(best_q);
      rr_q <= '0;
      rb_q <= 36'(1) << 34;
    end else if (ctrl_i.step) begin
      it_q <= it_q + 5'd1;
      if (32'(it_q) < NIter) begin
        if (!cy_q[CW-1]) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          z_q  <= z_q + atan_lut(it_q);
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          z_q  <= z_q - atan_lut(it_q);
        end
      end
      if (rb_q != '0) begin
        if (36'(rn_q) >= trial) begin
          rn_q <= 34'(36'(rn_q) - trial);
          rr_q <= 34'((rr_q >> 1) + 34'(rb_q));
        end else begin
          rr_q <= rr_q >> 1;
        end
        rb_q <= rb_q >> 2;
      end
    end
  end

  assign stat_o.done = (32'(it_q) >= Iters - 1);

  assign found_o        = have_q;
  assign range_o        = have_q ? rr_q[15:0] : NoRange;
  assign bearing_o      = have_q ? ((zero_vec ? 16'd0 : z_q) - head_q) : 16'sd0;
  assign nearest_word_o = bword_q;
endmodule

/* hdl/nearest_peer_range_bearing.sv */
// Nearest peer range and bearing: a scan takes one peer per cycle; after the
// last peer's transfer a start step, then 18 root steps (or ANGLE_STEPS angle
// steps if the CORDIC needs more, capped at the table length) run in one shared
// sequencer before the result is offered, and the next scan is taken from the
// cycle after the result transfer. Coordinates are 16 bit, fixed by the package.
// Depends on nprb_pkg, nprb_if, nprb_ctrl, nprb_dp.
module nearest_peer_range_bearing #(
  parameter int unsigned ANGLE_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  nprb_if.sink        in_if,
  nprb_if.source      out_if
);
  import nprb_pkg::*;

  logic [15:0] max_range_q;
  ctrl_t ctrl;
  stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_range_q <= 16'd1024;
    end else if (cfg_we_i) begin
      max_range_q <= cfg_wdata_i;
    end
  end

  nprb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_last_i  (in_if.data.last_peer),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .ctrl_o     (ctrl),
    .stat_i     (stat)
  );

  nprb_dp #(.CoordWidth(CoordWidth), .AngleSteps(ANGLE_STEPS)) u_dp (
    .clk_i, .rst_ni,
    .max_range_i   (max_range_q),
    .own_x_i       (in_if.data.own_x),
    .own_y_i       (in_if.data.own_y),
    .own_heading_i (in_if.data.own_heading),
    .peer_x_i      (in_if.data.peer_x),
    .peer_y_i      (in_if.data.peer_y),
    .peer_word_i   (in_if.data.peer_word),
    .peer_is_self_i(in_if.data.peer_is_self),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .found_o       (out_if.data.found),
    .range_o       (out_if.data.range),
    .bearing_o     (out_if.data.bearing),
    .nearest_word_o(out_if.data.nearest_word)
  );
endmodule
